// File: rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants of the cone support point unit
// Feature codes, register indexes and the pipeline geometry.
// ----------------------------------------------------------------------------
package csp_pkg;

  typedef logic [1:0] feat_t;

  localparam feat_t FEAT_ZERO   = 2'd0;
  localparam feat_t FEAT_APEX   = 2'd1;
  localparam feat_t FEAT_RIM    = 2'd2;
  localparam feat_t FEAT_CENTER = 2'd3;

  localparam logic [1:0] REG_BASE_RADIUS = 2'd0;
  localparam logic [1:0] REG_QUARTER_HT  = 2'd1;
  localparam logic [1:0] REG_SINE_HALF   = 2'd2;
  localparam logic [1:0] REG_EPSILON     = 2'd3;

  // Root width of the 64-bit square roots and quotient width of the dividers.
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned QUO_W  = 31;

  // Stages ahead of the roots, then root, compare, divide and output stages.
  localparam int unsigned PIPE_LAT = 4 + ROOT_W + 2 + QUO_W + 1;

  typedef struct packed {
    logic        sx;
    logic        sz;
    logic [31:0] y;
    logic [31:0] ax;
    logic [31:0] az;
  } csp_front_t;

  typedef struct packed {
    logic        sx;
    logic        sz;
    feat_t       feat;
    logic [31:0] py;
  } csp_back_t;

endpackage

// File: rtl/cone_support_point_unit.sv
// ----------------------------------------------------------------------------
// cone_support_point_unit: support point of a Y-axis cone for GJK queries
// Returns the cone point farthest along a Q16.16 direction vector.
// ----------------------------------------------------------------------------
// The unit accepts one direction beat per clock while the output is not stalled
// and passes each one, in order, through PIPE_LAT (70) register stages; the
// depth is set by the two bit-per-stage 32-stage square roots and the 31-stage
// dividers that scale the rim point.
// A stalled output freezes the whole pipeline. Registers may be written over
// the APB port only while no beat is in flight.
module cone_support_point_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic [31:0] out_point_z,
  output csp_pkg::feat_t out_which_feature,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import csp_pkg::*;

  logic [30:0] base_radius_r, quarter_height_r;
  logic [16:0] sine_half_r, epsilon_r;
  logic        cfg_wr;

  logic                adv;
  logic [PIPE_LAT-1:0] vld_r;

  csp_front_t  front1_r, front2_r, front3_r, front4_r, front36;
  logic [63:0] ax2_r, ay2_r, az2_r, sxz3_r, ay3_r, tot4_r, sxz4_r;
  logic [31:0] norm36, s36;

  logic [48:0] rhs37_r;
  logic [47:0] lhs37_r;
  logic        nz37_r, sgt37_r, sx37_r, sz37_r;
  logic [62:0] numx37_r, numz37_r;
  logic [31:0] s37_r;

  csp_back_t   back38_r, back69;
  logic [62:0] numx38_r, numz38_r;
  logic [31:0] s38_r;
  logic [30:0] qx69, qz69;

  logic        apex;
  logic [32:0] qh3;
  csp_back_t   back_nxt;

  logic [31:0] px_r, py_r, pz_r;
  feat_t       feat_r;

  function automatic logic [31:0] front1_ay(input logic [31:0] v);
    front1_ay = v[31] ? 32'(-v) : v;
  endfunction

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_radius_r    <= 31'd65536;
      quarter_height_r <= 31'd65536;
      sine_half_r      <= 17'd15894;
      epsilon_r        <= 17'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BASE_RADIUS: base_radius_r    <= pwdata[30:0];
        REG_QUARTER_HT:  quarter_height_r <= pwdata[30:0];
        REG_SINE_HALF:   sine_half_r      <= pwdata[16:0];
        REG_EPSILON:     epsilon_r        <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BASE_RADIUS: prdata = {1'b0, base_radius_r};
      REG_QUARTER_HT:  prdata = {1'b0, quarter_height_r};
      REG_SINE_HALF:   prdata = {15'd0, sine_half_r};
      REG_EPSILON:     prdata = {15'd0, epsilon_r};
      default:         prdata = '0;
    endcase
  end

  // Global advance: the pipeline moves unless the output beat is held.
  assign adv      = !(vld_r[PIPE_LAT-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // Stages 1 to 4: magnitudes, squares, sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      front1_r.sx <= in_dir_x[31];
      front1_r.sz <= in_dir_z[31];
      front1_r.y  <= in_dir_y;
      front1_r.ax <= in_dir_x[31] ? 32'(-in_dir_x) : in_dir_x;
      front1_r.az <= in_dir_z[31] ? 32'(-in_dir_z) : in_dir_z;
      ay2_r       <= 64'(front1_ay(front1_r.y)) * 64'(front1_ay(front1_r.y));
      ay3_r       <= ay2_r;
      front2_r    <= front1_r;
      ax2_r       <= 64'(front1_r.ax) * 64'(front1_r.ax);
      az2_r       <= 64'(front1_r.az) * 64'(front1_r.az);
      front3_r    <= front2_r;
      sxz3_r      <= ax2_r + az2_r;
      front4_r    <= front3_r;
      tot4_r      <= sxz3_r + ay3_r;
      sxz4_r      <= sxz3_r;
    end
  end

  csp_isqrt u_norm (.clk(clk), .en(adv), .rad_i(tot4_r), .root_o(norm36));
  csp_isqrt u_rad  (.clk(clk), .en(adv), .rad_i(sxz4_r), .root_o(s36));

  csp_delay #(.W($bits(csp_front_t)), .D(ROOT_W)) u_front_dly (
    .clk(clk), .en(adv), .d_i(front4_r), .q_o(front36)
  );

  // Stage 37: products for the apex test and the rim numerators.
  always_ff @(posedge clk) begin
    if (adv) begin
      rhs37_r  <= 49'(norm36) * 49'(sine_half_r);
      lhs37_r  <= {front36.y, 16'd0};
      nz37_r   <= norm36 > {15'd0, epsilon_r};
      sgt37_r  <= s36 > {15'd0, epsilon_r};
      sx37_r   <= front36.sx;
      sz37_r   <= front36.sz;
      numx37_r <= 63'(front36.ax) * 63'(base_radius_r);
      numz37_r <= 63'(front36.az) * 63'(base_radius_r);
      s37_r    <= s36;
    end
  end

  // Stage 38: classify the direction.
  always_comb begin
    apex = nz37_r &&
           ($signed({{2{lhs37_r[47]}}, lhs37_r}) > $signed({1'b0, rhs37_r}));
    qh3  = {2'b00, quarter_height_r} + {1'b0, quarter_height_r, 1'b0};
    back_nxt.sx = sx37_r;
    back_nxt.sz = sz37_r;
    if (!nz37_r) begin
      back_nxt.feat = FEAT_ZERO;
      back_nxt.py   = '0;
    end else if (apex) begin
      back_nxt.feat = FEAT_APEX;
      back_nxt.py   = (qh3 > 33'h07FFFFFFF) ? 32'h7FFFFFFF : qh3[31:0];
    end else begin
      back_nxt.feat = sgt37_r ? FEAT_RIM : FEAT_CENTER;
      back_nxt.py   = 32'(-{1'b0, quarter_height_r});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      back38_r <= back_nxt;
      numx38_r <= numx37_r;
      numz38_r <= numz37_r;
      s38_r    <= s37_r;
    end
  end

  csp_div u_div_x (.clk(clk), .en(adv), .num_i(numx38_r), .den_i(s38_r), .quo_o(qx69));
  csp_div u_div_z (.clk(clk), .en(adv), .num_i(numz38_r), .den_i(s38_r), .quo_o(qz69));

  csp_delay #(.W($bits(csp_back_t)), .D(QUO_W)) u_back_dly (
    .clk(clk), .en(adv), .d_i(back38_r), .q_o(back69)
  );

  // Output stage: rim quotients never exceed the base radius, so no clamp.
  always_ff @(posedge clk) begin
    if (adv) begin
      feat_r <= back69.feat;
      py_r   <= back69.py;
      if (back69.feat == FEAT_RIM) begin
        px_r <= back69.sx ? 32'(-{1'b0, qx69}) : {1'b0, qx69};
        pz_r <= back69.sz ? 32'(-{1'b0, qz69}) : {1'b0, qz69};
      end else begin
        px_r <= '0;
        pz_r <= '0;
      end
    end
  end

  assign out_valid         = vld_r[PIPE_LAT-1];
  assign out_point_x       = px_r;
  assign out_point_y       = py_r;
  assign out_point_z       = pz_r;
  assign out_which_feature = feat_r;

endmodule

// File: rtl/csp_delay.sv
// ----------------------------------------------------------------------------
// csp_delay: enabled shift line
// Carries side data alongside the arithmetic stages, D beats deep.
// ----------------------------------------------------------------------------
module csp_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_r [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int unsigned k = 1; k < D; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q_o = tap_r[D-1];

endmodule

// File: rtl/csp_isqrt.sv
// ----------------------------------------------------------------------------
// csp_isqrt: pipelined integer square root
// Floor square root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module csp_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  import csp_pkg::*;

  logic [63:0] rem_r  [0:ROOT_W];
  logic [31:0] root_r [0:ROOT_W];

  always_comb begin
    rem_r[0]  = rad_i;
    root_r[0] = '0;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned BIT = ROOT_W - 1 - k;
    logic [65:0] trial;
    logic        take;

    // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
    always_comb begin
      trial = ({34'd0, root_r[k]} << (BIT + 1)) | (66'd1 << (2 * BIT));
      take  = {2'b00, rem_r[k]} >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? rem_r[k] - trial[63:0] : rem_r[k];
        root_r[k+1] <= take ? root_r[k] | (32'd1 << BIT) : root_r[k];
      end
    end
  end

  assign root_o = root_r[ROOT_W];

endmodule

// File: rtl/csp_div.sv
// ----------------------------------------------------------------------------
// csp_div: pipelined restoring divider
// Divides a 63-bit numerator by a 32-bit divisor, one quotient bit per stage.
// The quotient is known to fit in 31 bits.
// ----------------------------------------------------------------------------
module csp_div (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] num_i,
  input  logic [31:0] den_i,
  output logic [30:0] quo_o
);

  import csp_pkg::*;

  logic [31:0] rem_r [0:QUO_W];
  logic [30:0] low_r [0:QUO_W];
  logic [31:0] den_r [0:QUO_W];

  always_comb begin
    rem_r[0] = num_i[62:31];
    low_r[0] = num_i[30:0];
    den_r[0] = den_i;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [32:0] part;
    logic        take;

    always_comb begin
      part = {rem_r[k], low_r[k][QUO_W-1]};
      take = part >= {1'b0, den_r[k]};
    end

    // The low word shifts left and collects quotient bits at its bottom.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? 32'(part - {1'b0, den_r[k]}) : part[31:0];
        low_r[k+1] <= {low_r[k][QUO_W-2:0], take};
        den_r[k+1] <= den_r[k];
      end
    end
  end

  assign quo_o = low_r[QUO_W];

endmodule
